// ===== design/npcl_pkg.sv =====
// shared constants for the nearest point color lookup unit
package npcl_pkg;

    // store geometry
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);

    // distance arithmetic
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int DIST_BITS  = 2 * COORD_BITS + 2;

    // stream field widths
    localparam int OP_BITS    = 2;
    localparam int POS_BITS   = 16;
    localparam int COLOR_BITS = 8;
    localparam int NIDX_BITS  = 10;
    localparam int NDIST_BITS = 34;
    localparam int S_DATA_BITS = 72;
    localparam int M_DATA_BITS = 72;
    localparam int M_USED_BITS = 3 * COLOR_BITS + NIDX_BITS + NDIST_BITS;

    // one stored entry: x, y, z, red, green, blue from the lowest bit up
    localparam int ENTRY_BITS = 3 * COORD_BITS + 3 * COLOR_BITS;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

endpackage

// ===== design/npcl_ram.sv =====
// generic single-write, single-read ram with registered read data
module npcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/nearest_point_color_lookup_unit.sv =====
// top level of the nearest point color lookup unit
//
// Keeps up to MAX_POINTS colored reference points in one on-chip ram and
// answers nearest-point queries by brute force. A clear item (tuser 0) empties
// the store and a load item (tuser 1) appends one point; both give no result.
// A load into a full store instead gives one result with the fault flag set
// and all other fields zero, passed through the finish state into the output
// register, and the input is held meanwhile. A query item (tuser 2) scans the
// stored points in index order, one ram read per cycle, through a difference,
// square, sum and compare pipeline; no new item is taken until its result is
// registered. Ties keep the lower index. A query on an empty store gives a
// fault result through the finish state. Operation code 3 is dropped. A
// finished result waits in the output register while clears, loads and the
// next scan go on; a second result waits in the finish state and holds the
// input until the output register frees. The ram has no reset: only entries
// below the point count ever reach a result.
module nearest_point_color_lookup_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], color_red[55:48],
    // color_green[63:56], color_blue[71:64]
    input  logic [npcl_pkg::S_DATA_BITS-1:0] s_tdata,
    // operation[1:0]
    input  logic [npcl_pkg::OP_BITS-1:0]     s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // near_red[7:0], near_green[15:8], near_blue[23:16], near_index[33:24],
    // near_distance[67:34], zero[71:68]
    output logic [npcl_pkg::M_DATA_BITS-1:0] m_tdata,
    // fault_flag[0]
    output logic [0:0]                      m_tuser
);

    localparam int CB = npcl_pkg::COORD_BITS;
    localparam int KB = npcl_pkg::COLOR_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef logic signed [CB-1:0]                coord_t;
    typedef logic        [npcl_pkg::DIFF_BITS-1:0] mag_t;
    typedef logic        [npcl_pkg::SQ_BITS-1:0]   sq_t;
    typedef logic        [npcl_pkg::DIST_BITS-1:0] dist_t;
    typedef logic        [npcl_pkg::IDX_BITS-1:0]  idx_t;
    typedef logic        [3*KB-1:0]                color_t;

    // low COORD_BITS bits of a field taken as two's complement
    function automatic coord_t coord_of(input logic [npcl_pkg::POS_BITS-1:0] raw);
        return coord_t'(raw);
    endfunction

    function automatic mag_t abs_diff(input coord_t a, input coord_t b);
        logic signed [npcl_pkg::DIFF_BITS-1:0] d;
        d = npcl_pkg::DIFF_BITS'(a) - npcl_pkg::DIFF_BITS'(b);
        return d[npcl_pkg::DIFF_BITS-1] ? mag_t'(-d) : mag_t'(d);
    endfunction

    // input fields
    logic [npcl_pkg::POS_BITS-1:0] in_x, in_y, in_z;
    color_t                        in_color;
    logic                          accept;

    assign in_x     = s_tdata[15:0];
    assign in_y     = s_tdata[31:16];
    assign in_z     = s_tdata[47:32];
    assign in_color = s_tdata[71:48];

    // control state
    state_t                        state_reg;
    logic [npcl_pkg::CNT_BITS-1:0] count_reg;
    logic [npcl_pkg::CNT_BITS-1:0] issue_reg;
    logic                          v_rd_reg, v_df_reg, v_sq_reg, v_sm_reg;
    logic                          first_reg;
    logic                          fault_reg;
    logic                          m_tvalid_reg;
    logic [npcl_pkg::M_DATA_BITS-1:0] m_tdata_reg;
    logic                          m_tuser_reg;

    logic store_full;
    logic out_free;
    logic issue;
    logic scan_done;

    assign store_full = (count_reg == npcl_pkg::CNT_BITS'(npcl_pkg::MAX_POINTS));
    assign out_free   = !m_tvalid_reg || m_tready;
    // input side does not look at the result channel
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign issue      = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign scan_done  = (state_reg == ST_SCAN) && !issue &&
                        !v_rd_reg && !v_df_reg && !v_sq_reg && !v_sm_reg;

    // point store
    logic                            ram_we;
    logic [npcl_pkg::ENTRY_BITS-1:0] ram_wdata;
    logic [npcl_pkg::ENTRY_BITS-1:0] ram_rdata;

    assign ram_we    = accept && (s_tuser == npcl_pkg::OP_LOAD) && !store_full;
    assign ram_wdata = {in_color, coord_of(in_z), coord_of(in_y), coord_of(in_x)};

    npcl_ram #(
        .WIDTH (npcl_pkg::ENTRY_BITS),
        .DEPTH (npcl_pkg::MAX_POINTS)
    ) u_point_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[npcl_pkg::IDX_BITS-1:0]),
        .wr_data (ram_wdata),
        .rd_addr (issue_reg[npcl_pkg::IDX_BITS-1:0]),
        .rd_data (ram_rdata)
    );

    // query point, held for the whole scan
    coord_t q_x_reg, q_y_reg, q_z_reg;

    // scan pipeline payload
    idx_t   idx_rd_reg, idx_df_reg, idx_sq_reg, idx_sm_reg;
    color_t col_df_reg, col_sq_reg, col_sm_reg;
    mag_t   mag_x_reg, mag_y_reg, mag_z_reg;
    sq_t    sq_x_reg, sq_y_reg, sq_z_reg;
    dist_t  dist_sm_reg;
    dist_t  best_dist_reg;
    idx_t   best_idx_reg;
    color_t best_col_reg;

    // stored entry fields from the ram
    coord_t p_x, p_y, p_z;
    assign p_x = ram_rdata[CB-1:0];
    assign p_y = ram_rdata[2*CB-1:CB];
    assign p_z = ram_rdata[3*CB-1:2*CB];

    logic take_best;
    assign take_best = v_sm_reg && (first_reg || (dist_sm_reg < best_dist_reg));

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == npcl_pkg::OP_QUERY)) begin
            q_x_reg <= coord_of(in_x);
            q_y_reg <= coord_of(in_y);
            q_z_reg <= coord_of(in_z);
        end
        // read stage
        idx_rd_reg <= issue_reg[npcl_pkg::IDX_BITS-1:0];
        // difference stage
        mag_x_reg  <= abs_diff(q_x_reg, p_x);
        mag_y_reg  <= abs_diff(q_y_reg, p_y);
        mag_z_reg  <= abs_diff(q_z_reg, p_z);
        col_df_reg <= ram_rdata[npcl_pkg::ENTRY_BITS-1:3*CB];
        idx_df_reg <= idx_rd_reg;
        // square stage
        sq_x_reg   <= sq_t'(mag_x_reg) * sq_t'(mag_x_reg);
        sq_y_reg   <= sq_t'(mag_y_reg) * sq_t'(mag_y_reg);
        sq_z_reg   <= sq_t'(mag_z_reg) * sq_t'(mag_z_reg);
        col_sq_reg <= col_df_reg;
        idx_sq_reg <= idx_df_reg;
        // sum stage
        dist_sm_reg <= npcl_pkg::DIST_BITS'(sq_x_reg) + npcl_pkg::DIST_BITS'(sq_y_reg)
                     + npcl_pkg::DIST_BITS'(sq_z_reg);
        col_sm_reg  <= col_sq_reg;
        idx_sm_reg  <= idx_sq_reg;
        // compare stage: strict less keeps the earlier point on a tie
        if (take_best) begin
            best_dist_reg <= dist_sm_reg;
            best_idx_reg  <= idx_sm_reg;
            best_col_reg  <= col_sm_reg;
        end
    end

    // control and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            v_rd_reg     <= 1'b0;
            v_df_reg     <= 1'b0;
            v_sq_reg     <= 1'b0;
            v_sm_reg     <= 1'b0;
            first_reg    <= 1'b0;
            fault_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the finish state refills the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            v_rd_reg <= issue;
            v_df_reg <= v_rd_reg;
            v_sq_reg <= v_df_reg;
            v_sm_reg <= v_sq_reg;
            if (v_sm_reg) begin
                first_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_tuser)
                            npcl_pkg::OP_CLEAR: begin
                                count_reg <= '0;
                            end
                            npcl_pkg::OP_LOAD: begin
                                if (store_full) begin
                                    // dropped load: fault result with zero fields
                                    state_reg <= ST_FINISH;
                                    fault_reg <= 1'b1;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            npcl_pkg::OP_QUERY: begin
                                if (count_reg == '0) begin
                                    state_reg <= ST_FINISH;
                                    fault_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_SCAN;
                                    issue_reg <= '0;
                                    first_reg <= 1'b1;
                                    fault_reg <= 1'b0;
                                end
                            end
                            default: begin
                                // unused code, dropped
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (scan_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= fault_reg;
                        if (fault_reg) begin
                            m_tdata_reg <= '0;
                        end else begin
                            m_tdata_reg <= npcl_pkg::M_DATA_BITS'({
                                npcl_pkg::NDIST_BITS'(best_dist_reg),
                                npcl_pkg::NIDX_BITS'(best_idx_reg),
                                best_col_reg
                            });
                        end
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== design/npcl_checker.sv =====
// port-level checks for the nearest point color lookup unit, bound to the top level
module npcl_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [npcl_pkg::OP_BITS-1:0]     s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [npcl_pkg::M_DATA_BITS-1:0] m_tdata,
    input logic [0:0]                       m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a fault result carries all-zero fields
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("fault result with nonzero fields");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a clear never causes a result
    a_clear_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == npcl_pkg::OP_CLEAR) &&
        !(m_tvalid && !m_tready) |=> !m_tvalid)
        else $error("result after clear");

endmodule

bind nearest_point_color_lookup_unit npcl_checker u_npcl_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the nearest point color lookup unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import npcl_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 20000;
    // longest scan of a full store plus pipeline margin
    localparam int SETTLE_CYCLES  = MAX_POINTS + 64;
    localparam int SESSION_ITEMS  = 110;
    // size of the large point set
    localparam int FILL_POINTS    = 200;

    // operation code that the block drops
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [POS_BITS-1:0]   x;
        logic [POS_BITS-1:0]   y;
        logic [POS_BITS-1:0]   z;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } point_item_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [NIDX_BITS-1:0]  index;
        logic [NDIST_BITS-1:0] distance;
        logic                  fault;
    } nearest_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic [OP_BITS-1:0]     s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic [0:0]             m_tuser;

    nearest_point_color_lookup_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // idle chances in percent, changed between phases
    int send_idle_pct = 25;
    int recv_idle_pct = 83;

    int error_count    = 0;
    int pushed_items   = 0;
    int accepted_items = 0;
    int quiet_cycles   = 0;

    point_item_t pending_items[$];
    point_item_t cur_item;
    nearest_t    nearest_q[$];
    nearest_t    want;

    // shadow of the point store
    logic signed [POS_BITS-1:0] pt_x [MAX_POINTS];
    logic signed [POS_BITS-1:0] pt_y [MAX_POINTS];
    logic signed [POS_BITS-1:0] pt_z [MAX_POINTS];
    logic [COLOR_BITS-1:0]      pt_red [MAX_POINTS];
    logic [COLOR_BITS-1:0]      pt_green [MAX_POINTS];
    logic [COLOR_BITS-1:0]      pt_blue [MAX_POINTS];
    int                         pt_count = 0;

    // points loaded since the last clear, as seen by the stimulus side
    point_item_t loaded_pts[$];

    // update the shadow store and queue the result an accepted item causes
    task automatic predict_item(input point_item_t it);
        nearest_t res;
        longint   dx;
        longint   dy;
        longint   dz;
        longint   sq_dist;
        longint   best;
        int       best_idx;
        int       i;
        res       = '0;
        res.fault = 1'b1;
        case (it.op)
            OP_CLEAR: begin
                pt_count = 0;
            end
            OP_LOAD: begin
                if (pt_count >= MAX_POINTS) begin
                    // full store: point dropped, fault result
                    nearest_q = {nearest_q, res};
                end else begin
                    pt_x[pt_count]     = it.x;
                    pt_y[pt_count]     = it.y;
                    pt_z[pt_count]     = it.z;
                    pt_red[pt_count]   = it.red;
                    pt_green[pt_count] = it.green;
                    pt_blue[pt_count]  = it.blue;
                    pt_count++;
                end
            end
            OP_QUERY: begin
                if (pt_count > 0) begin
                    best     = 64'h7fff_ffff_ffff_ffff;
                    best_idx = 0;
                    for (i = 0; i < pt_count; i++) begin
                        dx = longint'($signed(it.x)) - longint'(pt_x[i]);
                        dy = longint'($signed(it.y)) - longint'(pt_y[i]);
                        dz = longint'($signed(it.z)) - longint'(pt_z[i]);
                        sq_dist = dx * dx + dy * dy + dz * dz;
                        // strict compare keeps the earlier point on a tie
                        if (sq_dist < best) begin
                            best     = sq_dist;
                            best_idx = i;
                        end
                    end
                    res.red      = pt_red[best_idx];
                    res.green    = pt_green[best_idx];
                    res.blue     = pt_blue[best_idx];
                    res.index    = NIDX_BITS'(best_idx);
                    res.distance = NDIST_BITS'(best);
                    res.fault    = 1'b0;
                end
                nearest_q = {nearest_q, res};
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(input string name, input logic [63:0] expv,
                                        input logic [63:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endfunction

    // input side: one item in flight, next one taken from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(cur_item);
                accepted_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.blue, cur_item.green, cur_item.red,
                                 cur_item.z, cur_item.y, cur_item.x};
                    s_tuser  <= cur_item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: random backpressure and field-by-field compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (nearest_q.size() == 0) begin
                    $error("result with no expectation waiting: data %h fault %b",
                           m_tdata, m_tuser);
                    error_count++;
                end else begin
                    want = nearest_q.pop_front();
                    check_field("near_red", want.red, m_tdata[7:0]);
                    check_field("near_green", want.green, m_tdata[15:8]);
                    check_field("near_blue", want.blue, m_tdata[23:16]);
                    check_field("near_index", want.index, m_tdata[33:24]);
                    check_field("near_distance", want.distance, m_tdata[67:34]);
                    check_field("fault_flag", want.fault, m_tuser[0]);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // mostly full range, sometimes a small cluster around zero or an extreme
    function automatic logic [POS_BITS-1:0] rand_coord();
        int pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(3))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        if (pick < 30) begin
            return 16'($urandom_range(16)) - 16'd8;
        end
        return 16'($urandom);
    endfunction

    task automatic push_item(input logic [OP_BITS-1:0] op, input logic [POS_BITS-1:0] x,
                             input logic [POS_BITS-1:0] y, input logic [POS_BITS-1:0] z,
                             input logic [COLOR_BITS-1:0] r, input logic [COLOR_BITS-1:0] g,
                             input logic [COLOR_BITS-1:0] b);
        point_item_t it;
        it = '{op, x, y, z, r, g, b};
        pending_items = {pending_items, it};
        pushed_items++;
        case (op)
            OP_CLEAR: loaded_pts.delete();
            OP_LOAD:  if (loaded_pts.size() < MAX_POINTS) loaded_pts = {loaded_pts, it};
            default: ;
        endcase
    endtask

    task automatic push_load(input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y,
                             input logic [POS_BITS-1:0] z, input logic [COLOR_BITS-1:0] r,
                             input logic [COLOR_BITS-1:0] g, input logic [COLOR_BITS-1:0] b);
        push_item(OP_LOAD, x, y, z, r, g, b);
    endtask

    // unused fields of clears, queries and dropped items carry random bits
    task automatic push_query(input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y,
                              input logic [POS_BITS-1:0] z);
        push_item(OP_QUERY, x, y, z, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic push_clear();
        push_item(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic push_unused();
        push_item(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // new point, or a copy of a stored one with another color to force ties
    task automatic push_load_mixed();
        point_item_t p;
        if (loaded_pts.size() > 0 && $urandom_range(99) < 20) begin
            p = loaded_pts[$urandom_range(loaded_pts.size() - 1)];
            push_load(p.x, p.y, p.z, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            push_load(rand_coord(), rand_coord(), rand_coord(),
                      8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // query on a stored point, next to one, or anywhere
    task automatic push_query_mixed();
        point_item_t p;
        int          pick;
        pick = $urandom_range(99);
        if (loaded_pts.size() == 0 || pick >= 70) begin
            push_query(rand_coord(), rand_coord(), rand_coord());
        end else begin
            p = loaded_pts[$urandom_range(loaded_pts.size() - 1)];
            if (pick < 40) begin
                push_query(p.x, p.y, p.z);
            end else begin
                push_query(p.x + 16'($urandom_range(6)) - 16'd3,
                           p.y + 16'($urandom_range(6)) - 16'd3,
                           p.z + 16'($urandom_range(6)) - 16'd3);
            end
        end
    endtask

    // mostly clear, a small point set and a few queries; the rest is noise
    task automatic random_session(input int n_items);
        int made;
        int k;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(99) < 85) begin
                push_clear();
                made++;
                k = ($urandom_range(9) == 0) ? $urandom_range(80, 13) : $urandom_range(12, 1);
                repeat (k) begin
                    push_load_mixed();
                    made++;
                end
                repeat ($urandom_range(6, 1)) begin
                    push_query_mixed();
                    made++;
                end
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(3))
                        0: begin
                            push_clear();
                            made++;
                        end
                        1: begin
                            if (loaded_pts.size() < 200) push_load_mixed();
                            else push_clear();
                            made++;
                        end
                        2: begin
                            push_query_mixed();
                            made++;
                        end
                        default: push_unused();
                    endcase
                end
            end
        end
    endtask

    // hold the sender until every item is taken and every result is back
    task automatic wait_drained();
        @(posedge aclk);
        while (accepted_items != pushed_items || nearest_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        point_item_t p;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty store, extremes, ties, duplicates, dropped code
        push_query(16'h0000, 16'h0000, 16'h0000);
        push_item(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff);
        push_load(16'h8000, 16'h8000, 16'h8000, 8'h00, 8'h00, 8'h00);
        push_load(16'h7fff, 16'h7fff, 16'h7fff, 8'hff, 8'hff, 8'hff);
        push_query(16'h7fff, 16'h7fff, 16'h7fff);
        push_query(16'h8000, 16'h8000, 16'h8000);
        push_query(16'h0000, 16'h0000, 16'h0000);
        push_query(16'hffff, 16'hffff, 16'hffff);
        push_clear();
        push_query(16'h1234, 16'h8765, 16'h0f0f);
        push_load(16'h8000, 16'h8000, 16'h8000, 8'ha5, 8'h5a, 8'hc3);
        // largest possible distance
        push_query(16'h7fff, 16'h7fff, 16'h7fff);
        push_load(16'sd10, 16'h0000, 16'h0000, 8'h11, 8'h22, 8'h33);
        push_load(-16'sd10, 16'h0000, 16'h0000, 8'h44, 8'h55, 8'h66);
        // equal distance to both: lower index wins
        push_query(16'h0000, 16'h0000, 16'h0000);
        push_load(16'sd10, 16'h0000, 16'h0000, 8'h77, 8'h88, 8'h99);
        push_query(16'sd10, 16'h0000, 16'h0000);
        push_item(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        push_query(-16'sd10, 16'h0000, 16'h0000);
        push_clear();
        push_unused();
        push_query(16'h0001, 16'h0002, 16'h0003);
        wait_drained();

        // a large point set, queried on its last point, then grown further
        push_clear();
        repeat (FILL_POINTS) begin
            push_load(rand_coord(), rand_coord(), rand_coord(),
                      8'($urandom), 8'($urandom), 8'($urandom));
        end
        p = loaded_pts[FILL_POINTS - 1];
        push_query(p.x, p.y, p.z);
        push_query(16'h7fff, 16'h8000, 16'h7fff);
        push_query_mixed();
        push_load(rand_coord(), rand_coord(), rand_coord(), 8'hff, 8'h00, 8'hff);
        push_load(rand_coord(), rand_coord(), rand_coord(), 8'h00, 8'hff, 8'h00);
        push_query_mixed();
        push_clear();
        push_query(rand_coord(), rand_coord(), rand_coord());
        random_session(SESSION_ITEMS);
        wait_drained();

        send_idle_pct = 83;
        recv_idle_pct = 25;
        random_session(SESSION_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_session(SESSION_ITEMS);
        wait_drained();

        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
